FILE: sv/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA block cipher package
// Shared types and constants for the TEA half-round cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned KeyWords  = 4;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [WordWidth-1:0] TeaDelta = 32'h9e37_79b9;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } tea_mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_KEY_WORD_ZERO  = 2'd0,
    REG_KEY_WORD_ONE   = 2'd1,
    REG_KEY_WORD_TWO   = 2'd2,
    REG_KEY_WORD_THREE = 2'd3
  } tea_reg_e;

  typedef struct packed {
    logic                 mode;
    logic [WordWidth-1:0] block_first_half;
    logic [WordWidth-1:0] block_second_half;
  } tea_in_t;

  typedef struct packed {
    logic [WordWidth-1:0] result_first_half;
    logic [WordWidth-1:0] result_second_half;
  } tea_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 mode;
    logic [WordWidth-1:0] v0;
    logic [WordWidth-1:0] v1;
  } tea_stage_t;

  typedef logic [KeyWords-1:0][WordWidth-1:0] tea_key_t;

endpackage : tea_pkg

`default_nettype wire

FILE: sv/tea_half_round_cell.sv
// ----------------------------------------------------------------------------
// TEA half-round cell
// Updates one block half from the other under a fixed round sum and
// registers the block for the next cell in the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_half_round_cell import tea_pkg::*; #(
  parameter logic [31:0] SUM_ENC   = 32'h9e37_79b9,
  parameter logic [31:0] SUM_DEC   = 32'hc6ef_3720,
  parameter bit          IS_SECOND = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tea_key_t   key_i,
  input  tea_stage_t stage_i,
  output tea_stage_t stage_o
);

  logic                 update_v0;
  logic [WordWidth-1:0] src;
  logic [WordWidth-1:0] dst;
  logic [WordWidth-1:0] ka;
  logic [WordWidth-1:0] kb;
  logic [WordWidth-1:0] sum;
  logic [WordWidth-1:0] mix;
  logic [WordWidth-1:0] dst_new;
  logic                 valid_q;
  logic                 mode_q;
  logic [WordWidth-1:0] v0_q;
  logic [WordWidth-1:0] v1_q;
  logic [WordWidth-1:0] v0_d;
  logic [WordWidth-1:0] v1_d;

  // Encryption updates the first half before the second; decryption reverses it.
  assign update_v0 = (stage_i.mode == MODE_DECRYPT) ? IS_SECOND : !IS_SECOND;

  always_comb begin
    src = update_v0 ? stage_i.v1 : stage_i.v0;
    dst = update_v0 ? stage_i.v0 : stage_i.v1;
    ka  = update_v0 ? key_i[0] : key_i[2];
    kb  = update_v0 ? key_i[1] : key_i[3];
    sum = (stage_i.mode == MODE_DECRYPT) ? SUM_DEC : SUM_ENC;
    mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    dst_new = (stage_i.mode == MODE_DECRYPT) ? (dst - mix) : (dst + mix);
    v0_d = update_v0 ? dst_new : stage_i.v0;
    v1_d = update_v0 ? stage_i.v1 : dst_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= stage_i.mode;
    v0_q   <= v0_d;
    v1_q   <= v1_d;
  end

  assign stage_o = '{valid: valid_q, mode: mode_q, v0: v0_q, v1: v1_q};

endmodule : tea_half_round_cell

`default_nettype wire

FILE: sv/tea_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// TEA block cipher unit
// A block reaches the result strobe once it has passed the register of every half-round cell.
// Throughput: one block per cycle; busy stays low and a new block may start
// every cycle, carried by a chain of 2*ROUND_COUNT half-round cells.
// Reset clears the key registers to zero and flushes every block in flight.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_unit import tea_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  tea_in_t                  in_i,
  output logic                     result_valid_o,
  output tea_out_t                 result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [WordWidth-1:0]     cfg_data_i
);

  localparam int unsigned CellCount = 2 * ROUND_COUNT;

  tea_key_t   key_q;
  tea_stage_t chain [CellCount+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tea_reg_e'(cfg_index_i))
        REG_KEY_WORD_ZERO:  key_q[0] <= cfg_data_i;
        REG_KEY_WORD_ONE:   key_q[1] <= cfg_data_i;
        REG_KEY_WORD_TWO:   key_q[2] <= cfg_data_i;
        REG_KEY_WORD_THREE: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign chain[0] = '{valid: start && !busy, mode: in_i.mode,
                      v0: in_i.block_first_half, v1: in_i.block_second_half};

  for (genvar c = 0; c < CellCount; c++) begin : g_cell
    localparam int unsigned   Round   = c / 2;
    localparam logic [63:0]   ProdEnc = 64'(TeaDelta) * 64'(Round + 1);
    localparam logic [63:0]   ProdDec = 64'(TeaDelta) * 64'(ROUND_COUNT - Round);

    tea_half_round_cell #(
      .SUM_ENC  (ProdEnc[31:0]),
      .SUM_DEC  (ProdDec[31:0]),
      .IS_SECOND((c % 2) == 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .stage_i(chain[c]),
      .stage_o(chain[c+1])
    );
  end

  assign result_valid_o = chain[CellCount].valid;
  assign result_o = '{result_first_half:  chain[CellCount].v0,
                      result_second_half: chain[CellCount].v1};

endmodule : tea_block_cipher_unit

`default_nettype wire

FILE: sv/tea_block_cipher_unit_checker.sv
// ----------------------------------------------------------------------------
// TEA block cipher port checker
// Watches the top-level ports for handshake and latency behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_unit_checker #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic cfg_ready_o
);

  localparam int unsigned Latency = 2 * ROUND_COUNT;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised although the unit takes a block every cycle");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration transfer stalled");

  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Latency))
    else $error("result strobe without a matching start");

endmodule : tea_block_cipher_unit_checker

bind tea_block_cipher_unit tea_block_cipher_unit_checker #(
  .ROUND_COUNT(ROUND_COUNT)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

FILE: sim/tea_block_cipher_unit_tb.sv
// ----------------------------------------------------------------------------
// TEA block cipher unit testbench
// Sends blocks to the unit in both directions under several key settings,
// with idle gaps on the input side. Each accepted block is run through a
// local TEA model to get the block the unit must return. Every result strobe
// is checked field by field against the oldest block still in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_unit_tb import tea_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Rounds = 32;

  class cipher_tracker;
    logic [WordWidth-1:0] key_word [KeyWords];
    tea_out_t             blocks_in_flight [$];
    int unsigned          errors;
    int unsigned          encrypt_count;
    int unsigned          decrypt_count;
    int unsigned          checked_count;

    function new();
      foreach (key_word[i]) key_word[i] = '0;
      errors = 0;
      encrypt_count = 0;
      decrypt_count = 0;
      checked_count = 0;
    endfunction

    function void set_key(tea_reg_e idx, logic [WordWidth-1:0] data);
      key_word[idx] = data;
    endfunction

    function logic [WordWidth-1:0] mix_word(logic [WordWidth-1:0] v, logic [WordWidth-1:0] s,
                                            logic [WordWidth-1:0] ka,
                                            logic [WordWidth-1:0] kb);
      return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
    endfunction

    function tea_out_t tea_cipher(tea_in_t blk);
      logic [WordWidth-1:0] v0;
      logic [WordWidth-1:0] v1;
      logic [WordWidth-1:0] sum;
      tea_out_t             res;
      v0 = blk.block_first_half;
      v1 = blk.block_second_half;
      if (blk.mode == MODE_DECRYPT) begin
        sum = TeaDelta * Rounds;
        for (int unsigned r = 0; r < Rounds; r++) begin
          v1 -= mix_word(v0, sum, key_word[2], key_word[3]);
          v0 -= mix_word(v1, sum, key_word[0], key_word[1]);
          sum -= TeaDelta;
        end
      end else begin
        sum = '0;
        for (int unsigned r = 0; r < Rounds; r++) begin
          sum += TeaDelta;
          v0 += mix_word(v1, sum, key_word[0], key_word[1]);
          v1 += mix_word(v0, sum, key_word[2], key_word[3]);
        end
      end
      res.result_first_half  = v0;
      res.result_second_half = v1;
      return res;
    endfunction

    function void note_block(tea_in_t blk);
      if (blk.mode == MODE_DECRYPT) decrypt_count++;
      else encrypt_count++;
      blocks_in_flight.push_back(tea_cipher(blk));
    endfunction

    function void check_result(tea_out_t got);
      tea_out_t want;
      if (blocks_in_flight.size() == 0) begin
        $error("result strobe with no block in flight: %h", got);
        errors++;
        return;
      end
      want = blocks_in_flight.pop_front();
      checked_count++;
      if (got.result_first_half !== want.result_first_half) begin
        $error("result_first_half mismatch: expected %h, actual %h",
               want.result_first_half, got.result_first_half);
        errors++;
      end
      if (got.result_second_half !== want.result_second_half) begin
        $error("result_second_half mismatch: expected %h, actual %h",
               want.result_second_half, got.result_second_half);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return blocks_in_flight.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  tea_in_t                  blk_in = '0;
  logic                     result_valid;
  tea_out_t                 result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = REG_KEY_WORD_ZERO;
  logic [WordWidth-1:0]     cfg_data = '0;

  cipher_tracker tracker = new();
  int unsigned   idle_pct = 0;
  int unsigned   burst_left = 0;
  int unsigned   key_settings = 1;

  tea_block_cipher_unit #(
    .ROUND_COUNT(Rounds)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_i          (blk_in),
    .result_valid_o(result_valid),
    .result_o      (result),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid) tracker.check_result(result);
  end

  function automatic logic [WordWidth-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input tea_in_t blk);
    int unsigned gap;
    tea_in_t     noise;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(39) == 0) begin
      burst_left = $urandom_range(24, 8);
    end else if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
      noise = {1'($urandom_range(1)), $urandom, $urandom};
      start <= 1'b0;
      blk_in <= noise;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    blk_in <= blk;
    do @(posedge clk_i); while (busy);
    tracker.note_block(blk);
  endtask

  task automatic write_key(input tea_reg_e idx, input logic [WordWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.set_key(idx, data);
  endtask

  task automatic load_key(input logic [WordWidth-1:0] k0, input logic [WordWidth-1:0] k1,
                          input logic [WordWidth-1:0] k2, input logic [WordWidth-1:0] k3);
    write_key(REG_KEY_WORD_ZERO, k0);
    write_key(REG_KEY_WORD_ONE, k1);
    write_key(REG_KEY_WORD_TWO, k2);
    write_key(REG_KEY_WORD_THREE, k3);
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_corners();
    logic [WordWidth-1:0] first_half [6] = '{32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
                                             32'h8000_0000, 32'h0000_0001};
    logic [WordWidth-1:0] second_half [6] = '{32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
                                              32'h0000_0001, 32'h8000_0000};
    tea_in_t blk;
    foreach (first_half[i]) begin
      blk.block_first_half  = first_half[i];
      blk.block_second_half = second_half[i];
      blk.mode = MODE_ENCRYPT;
      send_block(blk);
      blk.mode = MODE_DECRYPT;
      send_block(blk);
    end
  endtask

  task automatic run_random(input int unsigned count);
    tea_in_t blk;
    repeat (count) begin
      blk.mode = $urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT;
      blk.block_first_half  = pick_word();
      blk.block_second_half = pick_word();
      send_block(blk);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 0;
    run_corners();
    run_random(120);
    drain();

    load_key('1, '1, '1, '1);
    idle_pct = 82;
    run_corners();
    run_random(150);
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    idle_pct = 13;
    run_random(150);
    drain();

    load_key('0, '1, 32'h8000_0000, 32'h0000_0001);
    idle_pct = 0;
    run_random(150);
    drain();

    load_key('0, '0, '0, '0);
    idle_pct = 82;
    run_random(120);
    drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    idle_pct = 13;
    run_random(150);
    drain();

    load_key(32'h0000_0001, 32'h8000_0000, '1, '0);
    idle_pct = 0;
    run_random(60);
    drain();

    repeat (2 * Rounds + 8) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $error("%0d blocks never came back", tracker.pending());
      tracker.errors++;
    end

    $display("Checked %0d cipher results (%0d encrypt, %0d decrypt) under %0d key settings,",
             tracker.checked_count, tracker.encrypt_count, tracker.decrypt_count,
             key_settings);
    $display("with input idle rates of 0, 13 and 82 percent and back-to-back bursts.");
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule : tea_block_cipher_unit_tb

`default_nettype wire

FILE: tea_block_cipher_unit.f
sv/tea_pkg.sv
sv/tea_half_round_cell.sv
sv/tea_block_cipher_unit.sv
sv/tea_block_cipher_unit_checker.sv
sim/tea_block_cipher_unit_tb.sv
